[src/stc_pkg.sv]
`timescale 1ns / 1ps
package stc_pkg;

  // command codes on the input channel
  localparam logic [2:0] CmdSample = 3'd0;
  localparam logic [2:0] CmdRight  = 3'd1;
  localparam logic [2:0] CmdLeft   = 3'd2;
  localparam logic [2:0] CmdUp     = 3'd3;
  localparam logic [2:0] CmdDown   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] RegDay   = 2'd0;
  localparam logic [1:0] RegEve   = 2'd1;
  localparam logic [1:0] RegNight = 2'd2;
  localparam int unsigned CfgAddrW = 4;

  localparam logic [4:0] DayReset   = 5'd7;
  localparam logic [4:0] EveReset   = 5'd17;
  localparam logic [4:0] NightReset = 5'd22;

  localparam int unsigned QueueDepth = 2;

  localparam int unsigned NumSlots = 3;
  localparam logic [2:0] ScrMain      = 3'd0;
  localparam logic [2:0] ScrSlotFirst = 3'd1;
  localparam logic [2:0] ScrSlotLast  = 3'd3;
  localparam logic [2:0] ScrTime      = 3'd4;

  localparam logic signed [7:0] HighReset [NumSlots] = '{8'sd26, 8'sd25, 8'sd28};
  localparam logic signed [7:0] LowReset  [NumSlots] = '{8'sd23, 8'sd22, 8'sd25};

  localparam logic [27:0]        ScaleNum      = 28'd33000;
  localparam logic signed [28:0] LimitScale    = 29'sd409500;
  localparam logic [11:0]        TempMax       = 12'd3300;
  localparam logic [27:0]        TempSatScaled = 28'd13517595;  // 3301 * 4095
  localparam logic [9:0]         DutyMax       = 10'd1000;
  localparam logic [27:0]        DutySatDiff   = 28'd4095000;   // 1000 * 4095

  typedef enum logic [2:0] {
    OpSample,
    OpRight,
    OpLeft,
    OpUp,
    OpDown,
    OpNone
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [11:0] adc;
    logic [4:0]  hour;
  } item_t;

  typedef struct packed {
    logic [4:0] day;
    logic [4:0] eve;
    logic [4:0] night;
  } cfg_t;

  typedef struct packed {
    logic [11:0]       temp_centi;
    logic              fan_on;
    logic [9:0]        fan_duty;
    logic              heater_on;
    logic [9:0]        heater_duty;
    logic [2:0]        screen;
    logic              edit_active;
    logic              cursor_on_low;
    logic signed [7:0] shown_high;
    logic signed [7:0] shown_low;
  } res_t;

  // floor(x / 4095) for x below 2^24: estimate via x * 4097 / 2^24, one correction step
  function automatic logic [12:0] div4095(input logic [23:0] x);
    logic [24:0] n;
    logic [12:0] q;
    logic [24:0] r;
    n = {1'b0, x} + 25'(x[23:12]);
    q = n[24:12];
    r = {1'b0, x} - {q, 12'b0} + 25'(q);
    if (r >= 25'd4095) begin
      q = q + 13'd1;
    end
    return q;
  endfunction

endpackage

[src/stc_front.sv]
`timescale 1ns / 1ps
module stc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           command_i,
  input  logic [11:0]          adc_sample_i,
  input  logic [4:0]           hour_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output stc_pkg::item_t       q_item_o
);

  logic           valid_q, valid_d;
  stc_pkg::item_t item_q, item_d;
  stc_pkg::op_e   op;
  logic           take;

  always_comb begin
    case (command_i)
      stc_pkg::CmdSample: op = stc_pkg::OpSample;
      stc_pkg::CmdRight:  op = stc_pkg::OpRight;
      stc_pkg::CmdLeft:   op = stc_pkg::OpLeft;
      stc_pkg::CmdUp:     op = stc_pkg::OpUp;
      stc_pkg::CmdDown:   op = stc_pkg::OpDown;
      default:            op = stc_pkg::OpNone;
    endcase
  end

  assign q_push_o   = valid_q && !q_full_i;
  assign in_stall_o = valid_q && q_full_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = take || (valid_q && !q_push_o);
    item_d  = item_q;
    if (take) begin
      item_d.op   = op;
      item_d.adc  = adc_sample_i;
      item_d.hour = hour_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign q_item_o = item_q;

endmodule

[src/stc_queue.sv]
`timescale 1ns / 1ps
module stc_queue #(
  parameter int unsigned Depth = stc_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  stc_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output stc_pkg::item_t pop_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  stc_pkg::item_t     mem_q [Depth];
  logic [PtrW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]    cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign pop_item_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

[src/stc_back.sv]
`timescale 1ns / 1ps
module stc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  stc_pkg::cfg_t  cfg_i,
  input  logic           q_valid_i,
  input  stc_pkg::item_t q_item_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output stc_pkg::res_t  result_o
);

  typedef struct packed {
    logic              sample;
    logic [27:0]       scaled;
    logic              fan_on;
    logic [27:0]       fan_diff;
    logic              heater_on;
    logic [27:0]       heater_diff;
    logic [2:0]        screen;
    logic              edit;
    logic              cursor;
    logic signed [7:0] shown_high;
    logic signed [7:0] shown_low;
  } exec_t;

  logic              s1_valid_q, s1_valid_d;
  exec_t             s1_q, s1_d;
  logic              out_valid_q, out_valid_d;
  stc_pkg::res_t     res_q, res_d;
  logic              adv;

  logic [2:0]        scr_q, scr_d;
  logic              edit_q, edit_d;
  logic              cursor_q, cursor_d;
  logic signed [7:0] hi_q [stc_pkg::NumSlots];
  logic signed [7:0] hi_d [stc_pkg::NumSlots];
  logic signed [7:0] lo_q [stc_pkg::NumSlots];
  logic signed [7:0] lo_d [stc_pkg::NumSlots];

  logic [1:0]        slot, eidx, sidx;
  logic              on_slot, shown_slot;
  logic signed [7:0] sel_hi, sel_lo, cur_h, cur_l, nh, nl;
  logic [27:0]       scaled;
  logic signed [28:0] scaled_s, hi_sc, lo_sc, dhi, dlo;
  logic [12:0]       temp_q13, fan_q13, heat_q13;

  // ---------------------------------------------------------------- execute stage
  assign adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign q_pop_o = q_valid_i && (!s1_valid_q || adv);

  always_comb begin
    if (q_item_i.hour >= cfg_i.day && q_item_i.hour < cfg_i.eve) begin
      slot = 2'd0;
    end else if (q_item_i.hour >= cfg_i.eve && q_item_i.hour < cfg_i.night) begin
      slot = 2'd1;
    end else begin
      slot = 2'd2;
    end
  end

  assign sel_hi   = hi_q[slot];
  assign sel_lo   = lo_q[slot];
  assign scaled   = 28'(q_item_i.adc) * stc_pkg::ScaleNum;
  assign scaled_s = signed'({1'b0, scaled});
  assign hi_sc    = 29'(sel_hi) * stc_pkg::LimitScale;
  assign lo_sc    = 29'(sel_lo) * stc_pkg::LimitScale;
  assign dhi      = scaled_s - hi_sc;
  assign dlo      = lo_sc - scaled_s;

  assign on_slot = scr_q inside {[stc_pkg::ScrSlotFirst:stc_pkg::ScrSlotLast]};
  assign eidx    = 2'(scr_q - 3'd1);
  assign cur_h   = hi_q[eidx];
  assign cur_l   = lo_q[eidx];

  always_comb begin
    scr_d    = scr_q;
    edit_d   = edit_q;
    cursor_d = cursor_q;
    hi_d     = hi_q;
    lo_d     = lo_q;
    nh       = cur_h;
    nl       = cur_l;
    if (q_pop_o) begin
      case (q_item_i.op)
        stc_pkg::OpRight: begin
          if (edit_q) begin
            edit_d = 1'b0;
          end else begin
            scr_d = (scr_q == stc_pkg::ScrTime) ? stc_pkg::ScrMain : scr_q + 3'd1;
          end
        end
        stc_pkg::OpLeft: begin
          if (on_slot) begin
            if (!edit_q) begin
              edit_d   = 1'b1;
              cursor_d = 1'b0;
            end else begin
              cursor_d = !cursor_q;
            end
          end
        end
        stc_pkg::OpUp: begin
          if (edit_q && on_slot) begin
            if (!cursor_q) begin
              nh = cur_h + 8'sd1;
            end else begin
              nl = cur_l + 8'sd1;
            end
            // raising one limit can push low above high: low follows high
            if (nl > nh) begin
              nl = nh;
            end
            hi_d[eidx] = nh;
            lo_d[eidx] = nl;
          end
        end
        stc_pkg::OpDown: begin
          if (edit_q && on_slot) begin
            if (!cursor_q) begin
              nh = cur_h - 8'sd1;
            end else begin
              nl = cur_l - 8'sd1;
            end
            if (nh < nl) begin
              nh = nl;
            end
            hi_d[eidx] = nh;
            lo_d[eidx] = nl;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign shown_slot = scr_d inside {[stc_pkg::ScrSlotFirst:stc_pkg::ScrSlotLast]};
  assign sidx       = 2'(scr_d - 3'd1);

  always_comb begin
    s1_valid_d = q_pop_o || (s1_valid_q && !adv);
    s1_d       = s1_q;
    if (q_pop_o) begin
      s1_d.sample      = (q_item_i.op == stc_pkg::OpSample);
      s1_d.scaled      = scaled;
      s1_d.fan_on      = !dhi[28] && (dhi != '0);
      s1_d.fan_diff    = dhi[27:0];
      s1_d.heater_on   = !dlo[28] && (dlo != '0);
      s1_d.heater_diff = dlo[27:0];
      s1_d.screen      = scr_d;
      s1_d.edit        = edit_d;
      s1_d.cursor      = cursor_d;
      s1_d.shown_high  = shown_slot ? hi_d[sidx] : 8'sd0;
      s1_d.shown_low   = shown_slot ? lo_d[sidx] : 8'sd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      scr_q      <= stc_pkg::ScrMain;
      edit_q     <= 1'b0;
      cursor_q   <= 1'b0;
      for (int i = 0; i < stc_pkg::NumSlots; i++) begin
        hi_q[i] <= stc_pkg::HighReset[i];
        lo_q[i] <= stc_pkg::LowReset[i];
      end
    end else begin
      s1_valid_q <= s1_valid_d;
      scr_q      <= scr_d;
      edit_q     <= edit_d;
      cursor_q   <= cursor_d;
      hi_q       <= hi_d;
      lo_q       <= lo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  // ---------------------------------------------------------------- result stage
  assign temp_q13 = stc_pkg::div4095(s1_q.scaled[23:0]);
  assign fan_q13  = stc_pkg::div4095(s1_q.fan_diff[23:0]);
  assign heat_q13 = stc_pkg::div4095(s1_q.heater_diff[23:0]);

  always_comb begin
    out_valid_d = adv || (out_valid_q && out_stall_i);
    res_d       = res_q;
    if (adv) begin
      res_d.screen        = s1_q.screen;
      res_d.edit_active   = s1_q.edit;
      res_d.cursor_on_low = s1_q.cursor;
      res_d.shown_high    = s1_q.shown_high;
      res_d.shown_low     = s1_q.shown_low;
      // temperature and drive levels only move on a sample, buttons report the last ones
      if (s1_q.sample) begin
        res_d.temp_centi = (s1_q.scaled >= stc_pkg::TempSatScaled) ?
                           stc_pkg::TempMax : temp_q13[11:0];
        res_d.fan_on     = s1_q.fan_on;
        if (!s1_q.fan_on) begin
          res_d.fan_duty = '0;
        end else if (s1_q.fan_diff >= stc_pkg::DutySatDiff) begin
          res_d.fan_duty = stc_pkg::DutyMax;
        end else begin
          res_d.fan_duty = fan_q13[9:0];
        end
        res_d.heater_on  = s1_q.heater_on;
        if (!s1_q.heater_on) begin
          res_d.heater_duty = '0;
        end else if (s1_q.heater_diff >= stc_pkg::DutySatDiff) begin
          res_d.heater_duty = stc_pkg::DutyMax;
        end else begin
          res_d.heater_duty = heat_q13[9:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

[src/scheduled_thermostat_controller_top.sv]
`timescale 1ns / 1ps
// Scheduled thermostat controller. Each request is a temperature sample or one button
// event; every request yields exactly one result, in order. The block takes one request
// per clock cycle when the result side keeps up: an input register classifies the
// command, a small queue (QDepth entries) decouples it from a two-stage back end that
// first updates the screen/edit state and scales the reading, then divides by 4095 and
// registers the result. A request passes the input, queue, execute and result registers.
// Slot boundary hours sit in three APB registers at 0x0, 0x4 and 0x8; write them only
// while no request is in flight.
module scheduled_thermostat_controller_top #(
  parameter int unsigned QDepth = stc_pkg::QueueDepth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [stc_pkg::CfgAddrW-1:0]         paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [2:0]                           command_i,
  input  logic [11:0]                          adc_sample_i,
  input  logic [4:0]                           hour_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [11:0]                          temp_centi_o,
  output logic                                 fan_on_o,
  output logic [9:0]                           fan_duty_o,
  output logic                                 heater_on_o,
  output logic [9:0]                           heater_duty_o,
  output logic [2:0]                           screen_o,
  output logic                                 edit_active_o,
  output logic                                 cursor_on_low_o,
  output logic signed [7:0]                    shown_high_o,
  output logic signed [7:0]                    shown_low_o
);

  stc_pkg::cfg_t  cfg_q, cfg_d;
  logic [1:0]     reg_idx;
  logic           wr_en;
  logic           q_full, q_push, q_pop, q_valid;
  stc_pkg::item_t push_item, pop_item;
  stc_pkg::res_t  result;

  // ---------------------------------------------------------------- register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        stc_pkg::RegDay:   cfg_d.day   = pwdata[4:0];
        stc_pkg::RegEve:   cfg_d.eve   = pwdata[4:0];
        stc_pkg::RegNight: cfg_d.night = pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      stc_pkg::RegDay:   prdata = 32'(cfg_q.day);
      stc_pkg::RegEve:   prdata = 32'(cfg_q.eve);
      stc_pkg::RegNight: prdata = 32'(cfg_q.night);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.day   <= stc_pkg::DayReset;
      cfg_q.eve   <= stc_pkg::EveReset;
      cfg_q.night <= stc_pkg::NightReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------------------------------------------------------- datapath
  stc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .adc_sample_i (adc_sample_i),
    .hour_i       (hour_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_item_o     (push_item)
  );

  stc_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  stc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (pop_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign temp_centi_o    = result.temp_centi;
  assign fan_on_o        = result.fan_on;
  assign fan_duty_o      = result.fan_duty;
  assign heater_on_o     = result.heater_on;
  assign heater_duty_o   = result.heater_duty;
  assign screen_o        = result.screen;
  assign edit_active_o   = result.edit_active;
  assign cursor_on_low_o = result.cursor_on_low;
  assign shown_high_o    = result.shown_high;
  assign shown_low_o     = result.shown_low;

  // ---------------------------------------------------------------- checks
  // limits are kept ordered, so fan and heater can never drive together
  a_fan_heater_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fan_on_o && heater_on_o))
    else $error("fan and heater both on");

  a_duty_needs_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((fan_duty_o != '0) |-> fan_on_o) and ((heater_duty_o != '0) |-> heater_on_o))
    else $error("duty without drive");

  a_limits_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (shown_low_o <= shown_high_o))
    else $error("low limit above high limit");

  a_blank_off_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (screen_o == stc_pkg::ScrMain || screen_o == stc_pkg::ScrTime))
    |-> (shown_high_o == 8'sd0 && shown_low_o == 8'sd0))
    else $error("limits shown off a slot screen");

endmodule
